// ----- design/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue unit: payload
// structs, operation and status codes, and the cell control and link types.
// ----------------------------------------------------------------------------
package deq_pkg;

   // number of cells in the chain and width of the entry count
   localparam int DEPTH = 64;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   // request operation codes
   localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
   localparam logic [1:0] MODE_PUSH_BACK  = 2'd1;
   localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
   localparam logic [1:0] MODE_POP_BACK   = 2'd3;

   // result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // request transfer payload
   typedef struct packed {
      logic [1:0]               mode;
      logic signed [DATA_W-1:0] push_value;
   } deq_req_type;

   // result transfer payload
   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      logic [1:0]               status;
      logic                     is_empty;
      logic [CNT_W-1:0]         entry_count;
   } deq_rsp_type;

   // operation broadcast to every cell of the chain
   typedef struct packed {
      logic              shift_in;     // push front: everything moves one cell back
      logic              shift_out;    // pop front: everything moves one cell forward
      logic              append;       // push back: first free cell takes the value
      logic              remove_last;  // pop back: last held cell is released
      logic [DATA_W-1:0] value;
   } deq_ctrl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic              occ;
      logic [DATA_W-1:0] data;
   } deq_link_type;

endpackage

// ----- design/deq_cell.sv -----
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the queue chain. Holds an entry and an occupied flag and moves
// them to or from its neighbors as the broadcast operation asks.
// ----------------------------------------------------------------------------
module deq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  deq_pkg::deq_ctrl_type ctrl,
   input  deq_pkg::deq_link_type prev_link,
   input  deq_pkg::deq_link_type next_link,
   output deq_pkg::deq_link_type link,
   output logic                  is_last
);
   import deq_pkg::*;

   logic              occ_ff, occ_in;
   logic [DATA_W-1:0] data_ff, data_in;

   // next contents from the neighbors or the pushed value
   always_comb begin
      occ_in  = occ_ff;
      data_in = data_ff;
      if (ctrl.shift_in) begin
         occ_in  = prev_link.occ;
         data_in = prev_link.data;
      end else if (ctrl.shift_out) begin
         occ_in  = next_link.occ;
         data_in = next_link.data;
      end else if (ctrl.append) begin
         if (!occ_ff && prev_link.occ) begin
            occ_in  = 1'b1;
            data_in = ctrl.value;
         end
      end else if (ctrl.remove_last) begin
         if (occ_ff && !next_link.occ) begin
            occ_in = 1'b0;
         end
      end
   end

   // occupied flag
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // entry data
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign link.occ  = occ_ff;
   assign link.data = data_ff;
   assign is_last   = occ_ff & ~next_link.occ;

endmodule

// ----- design/double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of 32-bit signed values built as a chain of
// cells, the front entry always in the first cell.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid / req_ready with req_payload carrying the
//   mode (push front, push back, pop front, pop back) and the value to push.
//   Every request gives exactly one result on rsp_valid / rsp_ready with the
//   popped value (zero unless a pop succeeded), a status (done, pop on empty,
//   push on full), the empty flag and the entry count after the request.
//   Latency: the result is valid the cycle after the request transfer.
//   Throughput: one request per cycle while the receiver keeps up; a push or
//   pop at the front moves the whole chain in one step, and a pop from the back
//   selects the last held cell through a one-hot select over all DEPTH cells.
//   The result register is released by a result transfer in the same cycle,
//   so req_ready stays high while rsp_ready is high; when the receiver stalls
//   req_ready drops until the waiting result is taken.
//   Reset empties the queue (all cells free, count zero) and drops any
//   waiting result; cell data is left as is and is never read while free.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  deq_pkg::deq_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output deq_pkg::deq_rsp_type rsp_payload
);
   import deq_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   deq_rsp_type      rsp_payload_ff, rsp_payload_in;

   logic              accept;
   logic              full;
   logic              empty;
   deq_ctrl_type      ctrl;
   deq_link_type      links     [DEPTH];
   deq_link_type      prev_links[DEPTH];
   deq_link_type      next_links[DEPTH];
   logic [DEPTH-1:0]  last_flags;
   logic [DEPTH-1:0]  occ_vec;
   logic [DATA_W-1:0] back_data;

   // handshake
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign full      = (count_ff == DEPTH_CNT);
   assign empty     = (count_ff == '0);

   // operation broadcast to the chain
   always_comb begin
      ctrl.shift_in    = accept && (req_payload.mode == MODE_PUSH_FRONT) && !full;
      ctrl.append      = accept && (req_payload.mode == MODE_PUSH_BACK) && !full;
      ctrl.shift_out   = accept && (req_payload.mode == MODE_POP_FRONT) && !empty;
      ctrl.remove_last = accept && (req_payload.mode == MODE_POP_BACK) && !empty;
      ctrl.value       = req_payload.push_value;
   end

   // neighbor links, the pushed value enters at the front
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0) begin
            prev_links[i].occ  = 1'b1;
            prev_links[i].data = req_payload.push_value;
         end else begin
            prev_links[i] = links[i-1];
         end
         if (i == DEPTH - 1) begin
            next_links[i].occ  = 1'b0;
            next_links[i].data = '0;
         end else begin
            next_links[i] = links[i+1];
         end
      end
   end

   // chain of cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      deq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .prev_link (prev_links[g]),
         .next_link (next_links[g]),
         .link      (links[g]),
         .is_last   (last_flags[g])
      );
      assign occ_vec[g] = links[g].occ;
   end

   // one-hot select of the back entry
   always_comb begin
      back_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_data = back_data | (links[i].data & {DATA_W{last_flags[i]}});
      end
   end

   // entry count and result
   always_comb begin
      count_in = count_ff;
      if (ctrl.shift_in || ctrl.append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.shift_out || ctrl.remove_last) begin
         count_in = count_ff - CNT_W'(1);
      end

      rsp_payload_in.popped_value = '0;
      rsp_payload_in.status       = ST_DONE;
      unique case (req_payload.mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (full) rsp_payload_in.status = ST_FULL;
         end
         MODE_POP_FRONT: begin
            if (empty) rsp_payload_in.status = ST_EMPTY;
            else rsp_payload_in.popped_value = links[0].data;
         end
         MODE_POP_BACK: begin
            if (empty) rsp_payload_in.status = ST_EMPTY;
            else rsp_payload_in.popped_value = back_data;
         end
         default: rsp_payload_in.status = ST_DONE;
      endcase
      rsp_payload_in.is_empty    = (count_in == '0);
      rsp_payload_in.entry_count = count_in;

      rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ready);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register, loaded on a request transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // occupied cells always match the entry count
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_vec) == 32'(count_ff))
      else $error("cell occupancy differs from entry count");

   // occupied cells form an unbroken run from the front
   a_packed_front: assert property (@(posedge clock) disable iff (reset)
      ((occ_vec + DEPTH'(1)) & occ_vec) == '0)
      else $error("occupied cells are not packed at the front");

   // a refused push leaves a full queue
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_FULL) |-> rsp_payload.entry_count == DEPTH_CNT)
      else $error("full status with a queue that is not full");

   // a refused pop leaves an empty queue and no value
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_EMPTY)
      |-> rsp_payload.is_empty && (rsp_payload.popped_value == '0))
      else $error("empty status with entries held or a value");

   // a waiting result holds while the receiver stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

endmodule

// ----- tb/double_ended_queue_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb
// Drives push and pop requests at both ends of the queue, predicts every
// result with a ring-buffer shadow of the queue and checks each result
// transfer field by field, under random idling and one long receiver stall.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;
   import deq_pkg::*;

   localparam int RANDOM_ITEMS = 1300;
   localparam int STALL_CYCLES = 200;
   localparam int MAX_REPORTS = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   deq_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   deq_rsp_type rsp_payload;

   // stimulus and expected results
   deq_req_type pending_items[$];
   deq_rsp_type expected_results[$];
   int          item_total = 0;
   int          accepted_count = 0;
   int          result_count = 0;
   int          fail_count = 0;

   // shadow of the queue contents
   logic signed [DATA_W-1:0] shadow_slots[DEPTH];
   int                       shadow_front = 0;
   int                       shadow_count = 0;

   // idling control
   logic [1:0] idle_phase;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         stall_left = 0;
   logic       stall_done = 1'b0;

   double_ended_queue_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sender busy first, then receiver, then neither idles
   assign idle_phase = (accepted_count < item_total / 3) ? 2'd0 :
                       (accepted_count < (2 * item_total) / 3) ? 2'd1 : 2'd2;
   assign send_idle_pct = (idle_phase == 2'd0) ? 36 : (idle_phase == 2'd1) ? 62 : 0;
   assign recv_idle_pct = (idle_phase == 2'd0) ? 62 : (idle_phase == 2'd1) ? 36 : 0;

   // apply one request to the shadow queue and return the result it gives
   function automatic deq_rsp_type apply_deque_op(input deq_req_type item);
      deq_rsp_type res;
      int          pos;
      res = '0;
      res.status = ST_DONE;
      case (item.mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               res.status = ST_FULL;
            end else if (item.mode == MODE_PUSH_FRONT) begin
               shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
               shadow_slots[shadow_front] = item.push_value;
               shadow_count++;
            end else begin
               pos = (shadow_front + shadow_count) % DEPTH;
               shadow_slots[pos] = item.push_value;
               shadow_count++;
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else if (item.mode == MODE_POP_FRONT) begin
               res.popped_value = shadow_slots[shadow_front];
               shadow_front = (shadow_front + 1) % DEPTH;
               shadow_count--;
            end else begin
               pos = (shadow_front + shadow_count - 1) % DEPTH;
               res.popped_value = shadow_slots[pos];
               shadow_count--;
            end
         end
      endcase
      res.is_empty = (shadow_count == 0);
      res.entry_count = CNT_W'(shadow_count);
      return res;
   endfunction

   task automatic add_item(input logic [1:0] mode, input logic [DATA_W-1:0] value);
      deq_req_type item;
      item.mode = mode;
      item.push_value = value;
      pending_items.push_back(item);
   endtask

   // values lean toward the extremes now and then
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // runs of requests that fill, drain or churn the queue
   task automatic build_random_runs();
      int push_pct;
      int run_len;
      int target;
      target = pending_items.size() + RANDOM_ITEMS;
      while (pending_items.size() < target) begin
         case ($urandom_range(3))
            0: push_pct = 90;
            1: push_pct = 10;
            default: push_pct = 50;
         endcase
         run_len = $urandom_range(110, 30);
         repeat (run_len) begin
            if ($urandom_range(99) < push_pct)
               add_item($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_value());
            else
               add_item($urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT, pick_value());
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(apply_deque_op(req_payload));
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off late in the run so the input backs up
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         stall_done <= 1'b0;
      end else if (!stall_done && accepted_count >= item_total - 150) begin
         stall_left <= STALL_CYCLES;
         stall_done <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // result receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      deq_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count <= result_count + 1;
         if (expected_results.size() == 0) begin
            fail_count <= fail_count + 1;
            if (fail_count < MAX_REPORTS)
               $display("result %0d arrived with nothing expected", result_count);
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload.popped_value !== want.popped_value ||
                rsp_payload.status !== want.status ||
                rsp_payload.is_empty !== want.is_empty ||
                rsp_payload.entry_count !== want.entry_count) begin
               fail_count <= fail_count + 1;
               if (fail_count < MAX_REPORTS) begin
                  $display("result %0d mismatch: exp value %0d status %0d empty %0b count %0d",
                           result_count, want.popped_value, want.status, want.is_empty,
                           want.entry_count);
                  $display("   got value %0d status %0d empty %0b count %0d",
                           rsp_payload.popped_value, rsp_payload.status,
                           rsp_payload.is_empty, rsp_payload.entry_count);
               end
            end
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      // pops on an empty queue, extreme values at both ends, front index wrap
      add_item(MODE_POP_FRONT, 32'h0000_0000);
      add_item(MODE_POP_BACK, 32'h5555_5555);
      add_item(MODE_PUSH_FRONT, 32'h7fff_ffff);
      add_item(MODE_PUSH_BACK, 32'h8000_0000);
      add_item(MODE_PUSH_FRONT, 32'hffff_ffff);
      add_item(MODE_PUSH_BACK, 32'h0000_0000);
      add_item(MODE_POP_BACK, 32'haaaa_aaaa);
      add_item(MODE_POP_FRONT, 32'h0000_0000);
      add_item(MODE_POP_BACK, 32'h0000_0000);
      add_item(MODE_POP_FRONT, 32'hffff_ffff);
      add_item(MODE_POP_FRONT, 32'h0000_0000);
      add_item(MODE_POP_BACK, 32'h0000_0000);
      add_item(MODE_PUSH_BACK, 32'h0000_0001);
      add_item(MODE_PUSH_FRONT, 32'h0000_0002);
      add_item(MODE_PUSH_BACK, 32'h8000_0001);
      add_item(MODE_POP_FRONT, 32'h0000_0000);
      add_item(MODE_POP_BACK, 32'h0000_0000);
      add_item(MODE_POP_BACK, 32'h0000_0000);
      add_item(MODE_POP_FRONT, 32'h0000_0000);
      build_random_runs();
      item_total = pending_items.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < item_total) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (expected_results.size() != 0)
         $display("%0d expected results never arrived", expected_results.size());
      if (fail_count == 0 && expected_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // run time limit
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule
